// ===== src/assert_macros.svh =====
// Assertion helper macros for the find-and-replace RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, clocked on aclk, masked while aresetn is low.
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, masked while aresetn is low.
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int LEN_W       = 4;
    localparam int POS_W       = 3;
    localparam int CNT_W       = 32;
    localparam int WORD_W      = 8 * MAX_PATTERN;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_BYTES  = 2'd0,
        CFG_SEARCH_LEN    = 2'd1,
        CFG_REPLACE_BYTES = 2'd2,
        CFG_REPLACE_LEN   = 2'd3
    } cfg_idx_t;

    // Live configuration with lengths already clamped to their legal ranges.
    typedef struct packed {
        logic [WORD_W-1:0] search_bytes;
        logic [LEN_W-1:0]  search_len;
        logic [WORD_W-1:0] replace_bytes;
        logic [LEN_W-1:0]  replace_len;
    } cfg_t;

    // All result words caused by one input word.
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] bytes;
        logic [LEN_W-1:0]            cnt;     // 1..MAX_PATTERN entries
        logic                        last;    // final entry closes the string
        logic                        marker;  // single empty end marker
        logic [CNT_W-1:0]            count;   // replacements, for the final entry
    } burst_t;

endpackage

// ===== src/sfr_cfg_regs.sv =====
// Configuration registers with clamped pattern and replacement lengths.
module sfr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]    cfg_wdata,
    output sfr_pkg::cfg_t                 cfg
);
    import sfr_pkg::*;

    logic [WORD_W-1:0] search_bytes_reg;
    logic [LEN_W-1:0]  search_len_reg;
    logic [WORD_W-1:0] replace_bytes_reg;
    logic [LEN_W-1:0]  replace_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_bytes_reg  <= '0;
            search_len_reg    <= LEN_W'(1);
            replace_bytes_reg <= '0;
            replace_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SEARCH_BYTES:  search_bytes_reg  <= cfg_wdata;
                CFG_SEARCH_LEN:    search_len_reg    <= cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_BYTES: replace_bytes_reg <= cfg_wdata;
                CFG_REPLACE_LEN:   replace_len_reg   <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.search_bytes  = search_bytes_reg;
        cfg.replace_bytes = replace_bytes_reg;
        // empty pattern acts as one byte; oversize lengths clamp to the maximum
        if (search_len_reg == '0)
            cfg.search_len = LEN_W'(1);
        else if (search_len_reg > LEN_W'(MAX_PATTERN))
            cfg.search_len = LEN_W'(MAX_PATTERN);
        else
            cfg.search_len = search_len_reg;
        if (replace_len_reg > LEN_W'(MAX_PATTERN))
            cfg.replace_len = LEN_W'(MAX_PATTERN);
        else
            cfg.replace_len = replace_len_reg;
    end

endmodule

// ===== src/sfr_match.sv =====
// Match engine: holds match position and hit count, builds each word's burst.
module sfr_match (
    input  logic            aclk,
    input  logic            aresetn,
    input  sfr_pkg::cfg_t   cfg,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            burst_push,
    output sfr_pkg::burst_t burst
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        SEG_NONE = 2'd0,
        SEG_CHAR = 2'd1,
        SEG_REPL = 2'd2
    } seg_t;

    localparam int SUM_W = 5;

    logic [POS_W-1:0] match_pos_reg, match_pos_next;
    logic [CNT_W-1:0] hit_count_reg, hit_count_next;

    logic [MAX_PATTERN-1:0][7:0] sb;
    logic [MAX_PATTERN-1:0][7:0] rb;

    assign sb = cfg.search_bytes;
    assign rb = cfg.replace_bytes;

    always_comb begin
        logic [LEN_W-1:0] pos_p1;
        logic [POS_W-1:0] pos_mid;
        logic [POS_W-1:0] p1;
        logic [POS_W-1:0] p2;
        seg_t             seg;
        logic [LEN_W-1:0] l2;
        logic [SUM_W-1:0] end1;
        logic [SUM_W-1:0] end2;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] off;
        logic [CNT_W-1:0] hits;

        pos_p1  = {1'b0, match_pos_reg} + LEN_W'(1);
        pos_mid = '0;
        p1      = '0;
        seg     = SEG_NONE;
        off     = '0;

        if (in_byte == sb[match_pos_reg]) begin
            if (pos_p1 >= cfg.search_len) seg = SEG_REPL;
            else                          pos_mid = pos_p1[POS_W-1:0];
        end else if (match_pos_reg != '0) begin
            // partial match broke: release the held prefix, retry on byte zero
            p1 = match_pos_reg;
            if (in_byte == sb[0]) begin
                if (cfg.search_len == LEN_W'(1)) seg = SEG_REPL;
                else                             pos_mid = POS_W'(1);
            end else begin
                seg = SEG_CHAR;
            end
        end else begin
            seg = SEG_CHAR;
        end

        case (seg)
            SEG_REPL: l2 = cfg.replace_len;
            SEG_CHAR: l2 = LEN_W'(1);
            default:  l2 = '0;
        endcase

        hits = hit_count_reg;
        if (seg == SEG_REPL && hit_count_reg != '1) hits = hit_count_reg + CNT_W'(1);

        // flush any prefix still held at the end of the string
        p2             = in_last ? pos_mid : '0;
        match_pos_next = in_last ? '0 : pos_mid;
        hit_count_next = in_last ? '0 : hits;

        end1  = SUM_W'(p1);
        end2  = end1 + SUM_W'(l2);
        total = end2 + SUM_W'(p2);

        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (SUM_W'(k) < end1) begin
                burst.bytes[k] = sb[k];
            end else if (SUM_W'(k) < end2) begin
                off = SUM_W'(k) - end1;
                burst.bytes[k] = (seg == SEG_REPL) ? rb[off[POS_W-1:0]] : in_byte;
            end else begin
                off = SUM_W'(k) - end2;
                burst.bytes[k] = sb[off[POS_W-1:0]];
            end
        end

        if (total == '0)
            burst.cnt = LEN_W'(1);
        else if (total > SUM_W'(MAX_PATTERN))
            burst.cnt = LEN_W'(MAX_PATTERN);
        else
            burst.cnt = total[LEN_W-1:0];
        burst.marker = (total == '0);
        burst.last   = in_last;
        burst.count  = hits;
        burst_push   = in_fire && (total != '0 || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_pos_reg <= '0;
            hit_count_reg <= '0;
        end else if (in_fire) begin
            match_pos_reg <= match_pos_next;
            hit_count_reg <= hit_count_next;
        end
    end

endmodule

// ===== src/sfr_out_buf.sv =====
// Result register: holds one burst and hands it out one word per cycle while m_ready is high.
module sfr_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            burst_push,
    input  sfr_pkg::burst_t burst_in,
    output logic            can_accept,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_byte_valid,
    output logic            m_out_last,
    output logic [31:0]     m_replace_count
);
    import sfr_pkg::*;

    logic             busy_reg;
    logic [POS_W-1:0] idx_reg;
    burst_t           burst_reg;

    logic take;
    logic at_end;

    assign at_end     = ({1'b0, idx_reg} + LEN_W'(1)) == burst_reg.cnt;
    assign take       = busy_reg && m_ready;
    assign can_accept = !busy_reg || (take && at_end);

    assign m_valid         = busy_reg;
    assign m_out_byte      = burst_reg.marker ? 8'd0 : burst_reg.bytes[idx_reg];
    assign m_byte_valid    = !burst_reg.marker;
    assign m_out_last      = burst_reg.last && at_end;
    assign m_replace_count = m_out_last ? burst_reg.count : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (burst_push) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (take && at_end) begin
            busy_reg <= 1'b0;
        end else if (take) begin
            idx_reg  <= idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (burst_push) burst_reg <= burst_in;
    end

endmodule

// ===== src/stream_find_and_replace_top.sv =====
// Top level of the streaming find-and-replace block.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | s_valid / s_ready  | s_in_byte, s_in_last
//  result   | m_valid / m_ready  | m_out_byte, m_byte_valid, m_out_last,
//           |                    | m_replace_count
//  config   | cfg_wr_en          | cfg_index, cfg_wdata (no wait, no read-back)
//
//  An input word is matched in the cycle it is accepted; its burst of zero to
//  eight result words lands in the result register at that edge.
//  The result register hands out one word per cycle while m_ready is high; a new
//  input word waits until the final word of the previous burst leaves, and input
//  words yielding no result are taken one per cycle while s_ready is high.
//  s_ready is high while the result register is empty or its final word leaves.
//  Reset clears match position, hit count and the result register; config
//  registers return to pattern length one, empty replacement.
module stream_find_and_replace_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]    cfg_wdata,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_in_last,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_byte_valid,
    output logic                          m_out_last,
    output logic [31:0]                   m_replace_count
);
    import sfr_pkg::*;

    `include "assert_macros.svh"

    cfg_t   cfg;
    burst_t burst;
    logic   burst_push;
    logic   in_fire;

    // accept an input word whenever the result register can take its burst
    assign in_fire = s_valid && s_ready;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // match against the live pattern, advance the position, build the burst
    sfr_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_fire    (in_fire),
        .in_byte    (s_in_byte),
        .in_last    (s_in_last),
        .burst_push (burst_push),
        .burst      (burst)
    );

    // hold the burst and drain it a word at a time
    sfr_out_buf u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .burst_push      (burst_push),
        .burst_in        (burst),
        .can_accept      (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_out_last      (m_out_last),
        .m_replace_count (m_replace_count)
    );

    // an empty result register never stalls the input side
    `SFR_ASSERT_IMP(a_idle_ready, !m_valid, s_ready, "input stalled with empty result register")
    // the empty marker only ever closes a string
    `SFR_ASSERT_IMP(a_marker_last, m_valid && !m_byte_valid, m_out_last && m_out_byte == 8'd0,
        "empty marker without last")
    // the count is shown on the closing word only
    `SFR_ASSERT_IMP(a_count_last, m_valid && !m_out_last, m_replace_count == '0,
        "replace count outside final word")
    // a word taken mid-burst leaves more of the burst behind
    `SFR_ASSERT_NXT(a_burst_hold, m_valid && m_ready && !s_ready, m_valid,
        "burst drained early")

endmodule
